// ===== sv/psq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package psq_pkg;

  // Command codes
  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_PEEK = 2'd1;
  localparam logic [1:0] CMD_POP  = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_NONE    = 2'd3;

  // Signal numbering
  localparam int unsigned SIG_BITS = 7;
  localparam int unsigned NUM_SIGS = 64;
  localparam int unsigned SIG_IDX_BITS = 6;
  localparam logic [SIG_BITS-1:0] SIG_FIRST = 7'd1;
  localparam logic [SIG_BITS-1:0] SIG_LAST  = 7'd64;

  // Configuration
  localparam logic [SIG_BITS-1:0] RT_START_RESET = 7'd34;
  localparam logic REG_RT_START = 1'b0;

  localparam logic [SIG_BITS-1:0] COUNT_MAX = 7'd127;

endpackage

`default_nettype wire

// ===== sv/psq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module psq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/pending_signal_queue_core.sv =====
// Pending signal store of one task.
// Command channel: drive command_i, signal_number_i, payload_i and
// blocked_mask_i with start; the word is taken at the edge where start is
// high and busy is low. busy stays high until the result has been shown.
// Result channel: result_valid_o is high for exactly one cycle and carries
// status_o, found_number_o, found_payload_o and pending_count_o. The
// receiver cannot stall; it must take the result in that cycle.
// Path from the accepting edge to the result cycle:
//   push, unused command, nothing pending to search: the result follows directly
//   peek/pop hitting a standard signal: ST_STD (payload RAM read), then the result
//   peek/pop from the realtime queue: ST_SCAN checks the entries in order,
//   a pop that closes the gap moves later entries down in ST_SHIFT, then the result.
// The scan and the compaction both walk the queue RAM, which has one read
// port and one write port, one entry per cycle.
// Configuration: APB register realtime_start at address 0. The user must
// write it only while busy is low; the block itself does not enforce this.
// Reset empties the store and sets realtime_start to 34.
`timescale 1ns / 1ps
`default_nettype none

module pending_signal_queue_core import psq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH  = 32,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // command channel
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              command_i,
  input  wire logic [SIG_BITS-1:0]     signal_number_i,
  input  wire logic [PAYLOAD_BITS-1:0] payload_i,
  input  wire logic [NUM_SIGS-1:0]     blocked_mask_i,
  // result channel
  output logic                         result_valid_o,
  output logic [1:0]                   status_o,
  output logic [SIG_BITS-1:0]          found_number_o,
  output logic [PAYLOAD_BITS-1:0]      found_payload_o,
  output logic [SIG_BITS-1:0]          pending_count_o,
  // configuration
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [2:0]              paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned QW = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CW = ((FW > SIG_BITS) ? FW : SIG_BITS) + 1;
  localparam int unsigned EW = SIG_BITS + PAYLOAD_BITS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_STD   = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_SHIFT = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [SIG_BITS-1:0]     rt_start_q;
  logic [NUM_SIGS-1:0]     std_pending_q, std_pending_d;
  logic [SIG_BITS-1:0]     std_cnt_q, std_cnt_d;
  logic [FW-1:0]           fill_q, fill_d;
  logic [QW-1:0]           idx_q, idx_d;
  logic                    pop_q, pop_d;
  logic [1:0]              status_q, status_d;
  logic [SIG_BITS-1:0]     found_num_q, found_num_d;
  logic [PAYLOAD_BITS-1:0] found_pl_q, found_pl_d;
  logic [NUM_SIGS-1:0]     mask_q, mask_d;

  logic                    std_we;
  logic [SIG_IDX_BITS-1:0] std_waddr;
  logic [SIG_IDX_BITS-1:0] std_raddr;
  logic [PAYLOAD_BITS-1:0] std_rdata;

  logic                    q_we;
  logic [QW-1:0]           q_waddr;
  logic [EW-1:0]           q_wdata;
  logic [QW-1:0]           q_raddr;
  logic [EW-1:0]           q_rdata;

  logic [NUM_SIGS-1:0]     hit;
  logic                    hit_any;
  logic [SIG_IDX_BITS-1:0] hit_idx;

  logic [FW:0]             idx_ext;
  logic [FW:0]             fill_ext;
  logic [SIG_BITS-1:0]     q_num;
  logic                    q_num_ok;
  logic                    sig_valid;
  logic [CW-1:0]           count_sum;
  logic                    cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_RT_START);
  assign prdata = (paddr[2] == REG_RT_START) ? {{(32 - SIG_BITS){1'b0}}, rt_start_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_start_q <= RT_START_RESET;
    end else if (cfg_wr) begin
      rt_start_q <= pwdata[SIG_BITS-1:0];
    end
  end

  // Lowest unblocked pending standard signal
  always_comb begin
    hit     = std_pending_q & ~blocked_mask_i;
    hit_any = |hit;
    hit_idx = '0;
    for (int i = NUM_SIGS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = SIG_IDX_BITS'(i);
      end
    end
  end

  assign idx_ext   = (FW + 1)'(idx_q);
  assign fill_ext  = (FW + 1)'(fill_q);
  assign q_num     = q_rdata[PAYLOAD_BITS +: SIG_BITS];
  assign q_num_ok  = (q_num >= SIG_FIRST) && (q_num <= SIG_LAST)
                     && !mask_q[SIG_IDX_BITS'(q_num - SIG_FIRST)];
  assign sig_valid = (signal_number_i >= SIG_FIRST) && (signal_number_i <= SIG_LAST);
  assign std_waddr = SIG_IDX_BITS'(signal_number_i - SIG_FIRST);

  always_comb begin
    state_d       = state_q;
    std_pending_d = std_pending_q;
    std_cnt_d     = std_cnt_q;
    fill_d        = fill_q;
    idx_d         = idx_q;
    pop_d         = pop_q;
    status_d      = status_q;
    found_num_d   = found_num_q;
    found_pl_d    = found_pl_q;
    mask_d        = mask_q;
    std_we        = 1'b0;
    std_raddr     = hit_idx;
    q_we          = 1'b0;
    q_waddr       = fill_q[QW-1:0];
    q_wdata       = {signal_number_i, payload_i};
    q_raddr       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          found_num_d = '0;
          found_pl_d  = '0;
          status_d    = STATUS_OK;
          mask_d      = blocked_mask_i;
          pop_d       = (command_i == CMD_POP);
          idx_d       = '0;
          state_d     = ST_RESP;
          unique case (command_i) inside
            CMD_PUSH: begin
              if (!sig_valid) begin
                status_d = STATUS_INVALID;
              end else if (signal_number_i >= rt_start_q) begin
                if (fill_q == FW'(QUEUE_DEPTH)) begin
                  status_d = STATUS_FULL;
                end else begin
                  q_we   = 1'b1;
                  fill_d = fill_q + 1'b1;
                end
              end else begin
                std_we = 1'b1;
                if (!std_pending_q[std_waddr]) begin
                  std_cnt_d = std_cnt_q + 1'b1;
                end
                std_pending_d[std_waddr] = 1'b1;
              end
            end
            CMD_PEEK, CMD_POP: begin
              if (hit_any) begin
                found_num_d = SIG_BITS'(hit_idx) + SIG_FIRST;
                if (command_i == CMD_POP) begin
                  std_pending_d[hit_idx] = 1'b0;
                  std_cnt_d              = std_cnt_q - 1'b1;
                end
                state_d = ST_STD;
              end else if (fill_q != '0) begin
                // read entry 0 now, check it next cycle
                state_d = ST_SCAN;
              end else begin
                status_d = STATUS_NONE;
              end
            end
            default: begin
              status_d = STATUS_INVALID;
            end
          endcase
        end
      end
      ST_STD: begin
        found_pl_d = std_rdata;
        state_d    = ST_RESP;
      end
      ST_SCAN: begin
        // prefetch the next entry while this one is checked
        q_raddr = QW'(idx_ext + 1'b1);
        if (q_num_ok) begin
          found_num_d = q_num;
          found_pl_d  = q_rdata[PAYLOAD_BITS-1:0];
          if (!pop_q) begin
            state_d = ST_RESP;
          end else if (idx_ext + 1'b1 < fill_ext) begin
            state_d = ST_SHIFT;
          end else begin
            fill_d  = fill_q - 1'b1;
            state_d = ST_RESP;
          end
        end else if (idx_ext + 1'b1 < fill_ext) begin
          idx_d = idx_q + 1'b1;
        end else begin
          status_d = STATUS_NONE;
          state_d  = ST_RESP;
        end
      end
      ST_SHIFT: begin
        // move entry idx+1 down to idx, fetch idx+2
        q_we    = 1'b1;
        q_waddr = idx_q;
        q_wdata = q_rdata;
        q_raddr = QW'(idx_ext + 2'd2);
        if (idx_ext + 2'd2 < fill_ext) begin
          idx_d = idx_q + 1'b1;
        end else begin
          fill_d  = fill_q - 1'b1;
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      std_pending_q <= '0;
      std_cnt_q     <= '0;
      fill_q        <= '0;
      idx_q         <= '0;
      pop_q         <= 1'b0;
      status_q      <= STATUS_OK;
      found_num_q   <= '0;
    end else begin
      state_q       <= state_d;
      std_pending_q <= std_pending_d;
      std_cnt_q     <= std_cnt_d;
      fill_q        <= fill_d;
      idx_q         <= idx_d;
      pop_q         <= pop_d;
      status_q      <= status_d;
      found_num_q   <= found_num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_pl_q <= found_pl_d;
    mask_q     <= mask_d;
  end

  psq_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (NUM_SIGS)
  ) u_std_ram (
    .clk_i   (clk_i),
    .we_i    (std_we),
    .waddr_i (std_waddr),
    .wdata_i (payload_i),
    .raddr_i (std_raddr),
    .rdata_o (std_rdata)
  );

  psq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  assign count_sum = CW'(std_cnt_q) + CW'(fill_q);

  assign busy            = (state_q != ST_IDLE);
  assign result_valid_o  = (state_q == ST_RESP);
  assign status_o        = status_q;
  assign found_number_o  = found_num_q;
  assign found_payload_o = found_pl_q;
  assign pending_count_o = (count_sum > CW'(COUNT_MAX)) ? COUNT_MAX
                                                         : count_sum[SIG_BITS-1:0];

endmodule

`default_nettype wire

// ===== sv/psq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module psq_checker import psq_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                result_valid_o,
  input wire logic [1:0]          status_o,
  input wire logic [SIG_BITS-1:0] found_number_o
);

  // an accepted word keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  // one result word per item, then back to idle
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o && !busy)
    else $error("result not followed by idle");

  // a result only appears while the item is still held
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result shown while idle");

  // a result with an error status reports no signal number
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != STATUS_OK) |-> found_number_o == '0)
    else $error("nonzero signal number with error status");

endmodule

bind pending_signal_queue_core psq_checker u_psq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .found_number_o (found_number_o)
);

`default_nettype wire
